// ===== rtl/bcd_stopwatch_display_scan_defines.svh =====
// ---------------------------------------------------------------------------
// Stopwatch display scan - assertion macros
// Shared concurrent assertion forms for the RTL modules.
// ---------------------------------------------------------------------------
`ifndef BCD_STOPWATCH_DISPLAY_SCAN_DEFINES_SVH
`define BCD_STOPWATCH_DISPLAY_SCAN_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BSDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define BSDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsds_pkg.sv =====
// ---------------------------------------------------------------------------
// Stopwatch display scan - package
// Shared types, register map and seven-segment decode.
// ---------------------------------------------------------------------------
package bsds_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index, decoded on paddr[2])
    localparam logic REG_DEBOUNCE_LIMIT  = 1'b0;
    localparam logic REG_TICKS_PER_COUNT = 1'b1;

    localparam logic [7:0] DEBOUNCE_LIMIT_RST  = 8'd20;
    localparam logic [7:0] TICKS_PER_COUNT_RST = 8'd2;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    localparam logic [3:0] EN_HUND   = 4'b1000;
    localparam logic [3:0] EN_TENTHS = 4'b0100;
    localparam logic [3:0] EN_SECS   = 4'b0010;
    localparam logic [3:0] EN_TENS   = 4'b0001;
    localparam logic [3:0] EN_NONE   = 4'b0000;

    typedef enum logic [2:0] {
        POS_HUND,
        POS_TENTHS,
        POS_SECS,
        POS_TENS,
        POS_BLANK
    } scan_pos_t;

    typedef struct packed {
        logic [7:0] debounce_limit;
        logic [7:0] ticks_per_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] secs;
        logic [3:0] tenths;
        logic [3:0] hund;
    } digits_t;

    typedef struct packed {
        digits_t digits;
        logic    running;
    } disp_t;

    // Active-low a..g plus point; codes above nine show blank
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'b1000_0000;
            4'd1:    s = 8'b1111_0010;
            4'd2:    s = 8'b0100_1000;
            4'd3:    s = 8'b0110_0000;
            4'd4:    s = 8'b0011_0010;
            4'd5:    s = 8'b0010_0100;
            4'd6:    s = 8'b0000_0100;
            4'd7:    s = 8'b1011_0000;
            4'd8:    s = 8'b0000_0000;
            4'd9:    s = 8'b0011_0000;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/bcd_stopwatch_display_scan.sv =====
// ---------------------------------------------------------------------------
// BCD stopwatch display scan - top level
// Stopwatch with debounced start/stop and multiplexed seven-segment output.
// ---------------------------------------------------------------------------
// Each input transaction is one scan tick carrying the start and second
// button levels. It yields four output transactions, one per digit
// (hundredths, tenths, seconds, ten-seconds) showing the count held before the
// tick, plus a fifth blank one when both buttons are down; tlast marks the
// final one. The timer state updates in the cycle the tick is taken, and the
// results then leave through a single output register at one per cycle unless
// m_tready stalls them. The next tick is taken in the same cycle as the
// previous tick's last result is loaded. Registers: debounce limit at 0x0
// (reset 20), prescaler period at 0x4 (reset 2).
// ---------------------------------------------------------------------------
module bcd_stopwatch_display_scan
(
    input  logic                        clk,
    input  logic                        rst_n,
    // stream in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] start_button, [1] second_button
    // stream out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [3:0] digit_enable, [11:4] segments,
                                                   // [12] running
    output logic                        m_tlast,
    // APB
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsds_pkg::ADDR_W-1:0] paddr,
    input  logic [bsds_pkg::DATA_W-1:0] pwdata,
    output logic [bsds_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    bsds_pkg::cfg_t  cfg;
    bsds_pkg::disp_t disp;
    logic            tick;
    logic            both_down;
    logic [3:0]      out_enable;
    logic [7:0]      out_segments;
    logic            out_running;

    assign tick      = s_tvalid && s_tready;
    assign both_down = s_tdata[0] && s_tdata[1];

    bsds_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsds_timer u_timer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .start_button (s_tdata[0]),
        .cfg          (cfg),
        .disp         (disp)
    );

    bsds_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (tick),
        .disp         (disp),
        .both_down    (both_down),
        .ready        (s_tready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_enable   (out_enable),
        .out_segments (out_segments),
        .out_running  (out_running),
        .out_last     (m_tlast)
    );

    assign m_tdata = {3'b000, out_running, out_segments, out_enable};

endmodule

// ===== rtl/bsds_regs.sv =====
// ---------------------------------------------------------------------------
// Stopwatch display scan - configuration registers
// APB register file for the debounce limit and the prescaler period.
// ---------------------------------------------------------------------------
module bsds_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsds_pkg::ADDR_W-1:0] paddr,
    input  logic [bsds_pkg::DATA_W-1:0] pwdata,
    output logic [bsds_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bsds_pkg::cfg_t             cfg
);

    bsds_pkg::cfg_t cfg_reg;
    bsds_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                bsds_pkg::REG_DEBOUNCE_LIMIT:  cfg_next.debounce_limit  = pwdata[7:0];
                bsds_pkg::REG_TICKS_PER_COUNT: cfg_next.ticks_per_count = pwdata[7:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_limit  <= bsds_pkg::DEBOUNCE_LIMIT_RST;
            cfg_reg.ticks_per_count <= bsds_pkg::TICKS_PER_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            bsds_pkg::REG_DEBOUNCE_LIMIT:  prdata = {24'd0, cfg_reg.debounce_limit};
            bsds_pkg::REG_TICKS_PER_COUNT: prdata = {24'd0, cfg_reg.ticks_per_count};
            default:                       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bsds_timer.sv =====
// ---------------------------------------------------------------------------
// Stopwatch display scan - timer
// Start/stop debounce, prescaler and 00.00 to 59.99 BCD count.
// ---------------------------------------------------------------------------
`include "bcd_stopwatch_display_scan_defines.svh"

module bsds_timer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,          // one scan tick taken this cycle
    input  logic             start_button,
    input  bsds_pkg::cfg_t   cfg,
    output bsds_pkg::disp_t  disp           // state as held before this tick
);

    bsds_pkg::digits_t digits_reg, digits_next;
    logic              counting_reg, counting_next;
    logic [7:0]        hold_reg, hold_next;
    logic              latched_reg, latched_next;
    logic [7:0]        prescale_reg, prescale_next;

    logic [7:0]        hold_inc;
    logic              press;
    logic [8:0]        pre_inc;
    logic              step;
    bsds_pkg::digits_t digits_pre;
    bsds_pkg::digits_t digits_adv;

    // Ripple of the BCD carries, wrapping 59.99 to 00.00
    always_comb
    begin
        digits_adv      = digits_pre;
        digits_adv.hund = digits_pre.hund + 4'd1;
        if (digits_adv.hund > 4'd9)
        begin
            digits_adv.hund   = 4'd0;
            digits_adv.tenths = digits_pre.tenths + 4'd1;
        end
        if (digits_adv.tenths > 4'd9)
        begin
            digits_adv.tenths = 4'd0;
            digits_adv.secs   = digits_pre.secs + 4'd1;
        end
        if (digits_adv.secs > 4'd9)
        begin
            digits_adv.secs = 4'd0;
            digits_adv.tens = digits_pre.tens + 3'd1;
        end
        if (digits_adv.tens > 3'd5)
        begin
            digits_adv.tens = 3'd0;
        end
    end

    always_comb
    begin
        hold_inc = (hold_reg != 8'hFF) ? hold_reg + 8'd1 : hold_reg;
        press    = start_button && (hold_inc > cfg.debounce_limit) && !latched_reg;

        digits_pre    = digits_reg;
        counting_next = counting_reg;
        hold_next     = hold_reg;
        latched_next  = latched_reg;
        digits_next   = digits_reg;
        prescale_next = prescale_reg;

        if (start_button)
        begin
            hold_next = hold_inc;
            if (press)
            begin
                latched_next  = 1'b1;
                counting_next = !counting_reg;
                if (!counting_reg)
                begin
                    digits_pre = '0;
                end
            end
        end
        else
        begin
            hold_next    = 8'd0;
            latched_next = 1'b0;
        end

        // A period of zero behaves as one
        pre_inc = {1'b0, prescale_reg} + 9'd1;
        step    = pre_inc >= {1'b0, cfg.ticks_per_count};
        if (step)
        begin
            prescale_next = 8'd0;
            digits_next   = counting_next ? digits_adv : digits_pre;
        end
        else
        begin
            prescale_next = pre_inc[7:0];
            digits_next   = digits_pre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg   <= '0;
            counting_reg <= 1'b1;
            hold_reg     <= 8'd0;
            latched_reg  <= 1'b0;
            prescale_reg <= 8'd0;
        end
        else if (tick)
        begin
            digits_reg   <= digits_next;
            counting_reg <= counting_next;
            hold_reg     <= hold_next;
            latched_reg  <= latched_next;
            prescale_reg <= prescale_next;
        end
    end

    assign disp.digits  = digits_reg;
    assign disp.running = counting_reg;

    `BSDS_ASSERT_NOW(a_bcd_range, 1'b1,
        (digits_reg.hund <= 4'd9) && (digits_reg.tenths <= 4'd9) &&
        (digits_reg.secs <= 4'd9) && (digits_reg.tens <= 3'd5),
        "timer: BCD digit out of range")
    `BSDS_ASSERT_NOW(a_latch_needs_hold, latched_reg, hold_reg != 8'd0,
        "timer: press latched without hold count")
    `BSDS_ASSERT_NEXT(a_hold_saturates, tick && start_button && (hold_reg == 8'hFF),
        hold_reg == 8'hFF, "timer: hold count wrapped")

endmodule

// ===== rtl/bsds_scan.sv =====
// ---------------------------------------------------------------------------
// Stopwatch display scan - scan sequencer
// Holds one tick's display snapshot and plays out its digit results.
// ---------------------------------------------------------------------------
`include "bcd_stopwatch_display_scan_defines.svh"

module bsds_scan
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,          // new tick taken
    input  bsds_pkg::disp_t disp,
    input  logic            both_down,
    output logic            ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [3:0]      out_enable,
    output logic [7:0]      out_segments,
    output logic            out_running,
    output logic            out_last
);

    logic                snap_valid_reg, snap_valid_next;
    bsds_pkg::scan_pos_t pos_reg, pos_next;
    bsds_pkg::disp_t     snap_reg;
    logic                both_reg;

    logic                out_valid_reg, out_valid_next;
    logic [3:0]          enable_reg;
    logic [7:0]          seg_reg;
    logic                running_reg;
    logic                last_reg;

    logic                out_free;
    logic                emit;
    logic [3:0]          cur_enable;
    logic [7:0]          cur_seg;
    logic                cur_last;

    always_comb
    begin
        case (pos_reg)
            bsds_pkg::POS_HUND:
            begin
                cur_enable = bsds_pkg::EN_HUND;
                cur_seg    = bsds_pkg::seg_code(snap_reg.digits.hund);
                cur_last   = 1'b0;
            end
            bsds_pkg::POS_TENTHS:
            begin
                cur_enable = bsds_pkg::EN_TENTHS;
                cur_seg    = bsds_pkg::seg_code(snap_reg.digits.tenths);
                cur_last   = 1'b0;
            end
            bsds_pkg::POS_SECS:
            begin
                cur_enable = bsds_pkg::EN_SECS;
                cur_seg    = bsds_pkg::seg_code(snap_reg.digits.secs);
                cur_last   = 1'b0;
            end
            bsds_pkg::POS_TENS:
            begin
                cur_enable = bsds_pkg::EN_TENS;
                cur_seg    = bsds_pkg::seg_code({1'b0, snap_reg.digits.tens});
                cur_last   = !both_reg;
            end
            bsds_pkg::POS_BLANK:
            begin
                cur_enable = bsds_pkg::EN_NONE;
                cur_seg    = bsds_pkg::SEG_BLANK;
                cur_last   = 1'b1;
            end
            default:
            begin
                cur_enable = bsds_pkg::EN_NONE;
                cur_seg    = bsds_pkg::SEG_BLANK;
                cur_last   = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = snap_valid_reg && out_free;
    // Next tick may enter as the final result of this one moves out
    assign ready    = !snap_valid_reg || (emit && cur_last);

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (cur_last)
            begin
                snap_valid_next = 1'b0;
                pos_next        = bsds_pkg::POS_HUND;
            end
            else
            begin
                pos_next = bsds_pkg::scan_pos_t'(pos_reg + 3'd1);
            end
        end
        if (load)
        begin
            snap_valid_next = 1'b1;
            pos_next        = bsds_pkg::POS_HUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            pos_reg        <= bsds_pkg::POS_HUND;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= disp;
            both_reg <= both_down;
        end
        if (emit)
        begin
            enable_reg  <= cur_enable;
            seg_reg     <= cur_seg;
            running_reg <= snap_reg.running;
            last_reg    <= cur_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_enable   = enable_reg;
    assign out_segments = seg_reg;
    assign out_running  = running_reg;
    assign out_last     = last_reg;

    `BSDS_ASSERT_NOW(a_blank_needs_both, snap_valid_reg && (pos_reg == bsds_pkg::POS_BLANK),
        both_reg, "scan: blank slot without both buttons")
    `BSDS_ASSERT_NOW(a_enable_onehot0, out_valid_reg, $onehot0(enable_reg),
        "scan: digit enable not one-hot")
    `BSDS_ASSERT_NOW(a_blank_is_last, out_valid_reg && (enable_reg == bsds_pkg::EN_NONE),
        last_reg, "scan: blank result not last of tick")

endmodule
